>>> hw/rtl/ber_pkg.sv
package ber_pkg;

	localparam int unsigned TICKS_W = 30;
	localparam logic [TICKS_W-1:0] TICKS_PER_SECOND = TICKS_W'(1000000000);
	localparam int unsigned BYTES_W = 32;
	localparam int unsigned STAMP_W = 64;
	localparam int unsigned RATE_W = 32;
	localparam int unsigned THR_W = 16;
	localparam int unsigned NUM_W = BYTES_W + 3 + TICKS_W;
	localparam int unsigned IN_W = BYTES_W + 2 * STAMP_W;
	localparam int unsigned OUT_W = 2 * RATE_W;
	localparam int unsigned USER_W = 2;
	localparam int unsigned CNT_W = $clog2(RATE_W);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(4588);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SAT,
		ST_DIV,
		ST_MEAN,
		ST_THR,
		ST_DEC,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic load_in;
		logic stage_diff;
		logic start_div;
		logic div_step;
		logic upd_mean;
		logic calc_thr;
		logic decide;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic have;
		logic sat;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hw/rtl/ber_ctrl.sv
module ber_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  ber_pkg::dp_stat_t stat,
	output ber_pkg::dp_cmd_t  cmd
);
	import ber_pkg::*;

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.stage_diff = 1'b1;
				state_d = stat.have ? ST_SAT : ST_OUT;
			end
			ST_SAT: begin
				cmd.start_div = 1'b1;
				state_d = stat.sat ? ST_MEAN : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.upd_mean = 1'b1;
				state_d = ST_THR;
			end
			ST_THR: begin
				cmd.calc_thr = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.decide = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DIFF))
		else $error("accepted request did not start processing");

	a_nosat_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAT && !stat.sat) |=> (state_q == ST_DIV))
		else $error("unsaturated rate skipped the divider");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !stat.div_last) |=> (state_q == ST_DIV))
		else $error("divider left early");

endmodule

>>> hw/rtl/ber_datapath.sv
module ber_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ber_pkg::dp_cmd_t              cmd,
	output ber_pkg::dp_stat_t             stat,
	input  logic [ber_pkg::IN_W-1:0]      s_tdata,
	input  logic                          cfg_valid,
	input  logic [ber_pkg::THR_W-1:0]     cfg_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ber_pkg::OUT_W-1:0]     m_tdata,
	output logic [ber_pkg::USER_W-1:0]    m_tuser
);
	import ber_pkg::*;

	logic [BYTES_W-1:0]  bytes_q;
	logic [STAMP_W-1:0]  dts_q;
	logic [STAMP_W-1:0]  pts_q;
	logic [STAMP_W-1:0]  prev_dts_q;
	logic [STAMP_W-1:0]  prev_pts_q;
	logic [STAMP_W-1:0]  diff_q;
	logic [NUM_W-1:0]    num_q;
	logic [STAMP_W-1:0]  rem_q;
	logic [RATE_W-1:0]   nlo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RATE_W-1:0]   rate_q;
	logic                measured_q;
	logic                report_q;
	logic [RATE_W-1:0]   avg_q;
	logic [RATE_W-1:0]   reported_q;
	logic [THR_W-1:0]    thr_q;
	logic [RATE_W+THR_W-1:0] thr_prod_q;
	logic [RATE_W-1:0]   absd_q;
	logic                m_tvalid_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic [RATE_W-1:0]   out_mean_q;
	logic                out_meas_q;
	logic                out_rep_q;

	logic                dec_pair;
	logic                pres_pair;
	logic                have_w;
	logic [STAMP_W-1:0]  diff_w;
	logic [NUM_W-4:0]    prod_w;
	logic [STAMP_W-1:0]  num_hi;
	logic                sat_w;
	logic [STAMP_W:0]    trial;
	logic [STAMP_W:0]    dext;
	logic                ge;
	logic [RATE_W+2:0]   mean_sum;
	logic [RATE_W-1:0]   big;
	logic [RATE_W-1:0]   absd_w;
	logic                report_w;

	always_comb begin
		dec_pair = (dts_q != '1) && (prev_dts_q != '1);
		pres_pair = (pts_q != '1) && (prev_pts_q != '1);
		have_w = 1'b0;
		diff_w = '0;
		if (dec_pair) begin
			have_w = dts_q > prev_dts_q;
			diff_w = dts_q - prev_dts_q;
		end else if (pres_pair) begin
			have_w = pts_q > prev_pts_q;
			diff_w = pts_q - prev_pts_q;
		end
	end

	assign prod_w = (NUM_W-3)'(bytes_q) * (NUM_W-3)'(TICKS_PER_SECOND);
	assign num_hi = STAMP_W'(num_q[NUM_W-1:RATE_W]);
	assign sat_w = num_hi >= diff_q;
	assign trial = {rem_q, nlo_q[RATE_W-1]};
	assign dext = {1'b0, diff_q};
	assign ge = trial >= dext;
	assign mean_sum = {avg_q, 3'b000} - (RATE_W+3)'(avg_q) + (RATE_W+3)'(rate_q);
	assign big = (avg_q > reported_q) ? avg_q : reported_q;
	assign absd_w = (avg_q > reported_q) ? (avg_q - reported_q) : (reported_q - avg_q);
	assign report_w = (reported_q == '0) || ({absd_q, {THR_W{1'b0}}} > thr_prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dts_q <= '1;
			prev_pts_q <= '1;
			avg_q <= '0;
			reported_q <= '0;
			thr_q <= THR_RESET;
			m_tvalid_q <= 1'b0;
			measured_q <= 1'b0;
			report_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (cmd.stage_diff) begin
				prev_dts_q <= dts_q;
				prev_pts_q <= pts_q;
				measured_q <= have_w;
				report_q <= 1'b0;
			end
			if (cmd.start_div) begin
				cnt_q <= CNT_W'(RATE_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.upd_mean) begin
				avg_q <= mean_sum[RATE_W+2:3];
			end
			if (cmd.decide) begin
				report_q <= report_w;
				if (report_w) begin
					reported_q <= avg_q;
				end
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			bytes_q <= s_tdata[BYTES_W-1:0];
			dts_q <= s_tdata[BYTES_W+STAMP_W-1:BYTES_W];
			pts_q <= s_tdata[IN_W-1:BYTES_W+STAMP_W];
		end
		if (cmd.stage_diff) begin
			diff_q <= diff_w;
			num_q <= {prod_w, 3'b000};
			rate_q <= '0;
		end
		if (cmd.start_div) begin
			rem_q <= num_hi;
			nlo_q <= num_q[RATE_W-1:0];
			rate_q <= sat_w ? '1 : '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? STAMP_W'(trial - dext) : trial[STAMP_W-1:0];
			nlo_q <= {nlo_q[RATE_W-2:0], 1'b0};
			rate_q <= {rate_q[RATE_W-2:0], ge};
		end
		if (cmd.calc_thr) begin
			thr_prod_q <= (RATE_W+THR_W)'(big) * (RATE_W+THR_W)'(thr_q);
			absd_q <= absd_w;
		end
		if (cmd.load_out) begin
			out_rate_q <= rate_q;
			out_mean_q <= avg_q;
			out_meas_q <= measured_q;
			out_rep_q <= report_q;
		end
	end

	assign stat.have = have_w;
	assign stat.sat = sat_w;
	assign stat.div_last = (cnt_q == '0);
	assign stat.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_mean_q, out_rate_q};
	assign m_tuser = {out_rep_q, out_meas_q};

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < diff_q))
		else $error("partial remainder not below divisor");

	a_report_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && report_w) |=> (reported_q == avg_q && report_q))
		else $error("reported rate not taken from mean");

	a_unmeasured_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && !measured_q) |=> (out_rate_q == '0 && !out_rep_q))
		else $error("unmeasured result carries a rate or a report");

endmodule

>>> hw/rtl/bitrate_ema_change_reporter.sv
// One buffer request at a time: s_tdata carries the byte count and the decode and presentation
// stamps; each accepted request yields exactly one result. The serial divider (one quotient bit
// per cycle) sets the throughput: a measured, unsaturated buffer runs through the divider
// before the next request is accepted, a saturated rate skips the divider, and a buffer without
// a usable positive stamp difference goes straight to the output stage. A finished result waits
// in the output register while the next request is accepted. The threshold register may be
// written only while no request is in flight; cfg_ready is always high.
module bitrate_ema_change_reporter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// buffer_bytes[31:0], decode_stamp[95:32], present_stamp[159:96]
	input  logic [ber_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// instant_bitrate[31:0], mean_bitrate[63:32]
	output logic [ber_pkg::OUT_W-1:0]   m_tdata,
	// rate_measured[0], report_now[1]
	output logic [ber_pkg::USER_W-1:0]  m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ber_pkg::THR_W-1:0]   cfg_data
);
	import ber_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ber_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ber_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
